[design/ycbd_pkg.sv]
// Shared types and constants for the YOLO cell box decoder.
// Depends on nothing; the controller, the datapath and the top level import it.
`timescale 1ns / 1ps

package ycbd_pkg;

  localparam int VALUE_FRAC_BITS = 16;
  localparam int COORD_BITS      = 13;
  localparam int MAX_CLASSES     = 256;
  localparam int HEADER_WORDS    = 5;

  localparam logic [8:0] NO_CLASS = 9'h1FF;

  // Header channel codes, in stream order
  localparam logic [2:0] HDR_X   = 3'd0;
  localparam logic [2:0] HDR_Y   = 3'd1;
  localparam logic [2:0] HDR_W   = 3'd2;
  localparam logic [2:0] HDR_H   = 3'd3;
  localparam logic [2:0] HDR_OBJ = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_SCORE_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_CLASS_COUNT     = 3'd1;
  localparam logic [2:0] REG_MODEL_WIDTH     = 3'd2;
  localparam logic [2:0] REG_MODEL_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_FILTER_A        = 3'd4;
  localparam logic [2:0] REG_FILTER_B        = 3'd5;
  localparam logic [2:0] REG_FILTER_C        = 3'd6;
  localparam logic [2:0] REG_FILTER_D        = 3'd7;

  typedef struct packed {
    logic [15:0] channel_value;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [6:0]  stride;
    logic [9:0]  anchor_width;
    logic [9:0]  anchor_height;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  class_id;
    logic [15:0] score;
    logic [12:0] top;
    logic [12:0] left;
    logic [12:0] bottom;
    logic [12:0] right;
  } out_word_t;

  typedef struct packed {
    logic [15:0] score_threshold;
    logic [8:0]  class_count;
    logic [12:0] model_width;
    logic [12:0] model_height;
    logic [8:0]  filtered_class_a;
    logic [8:0]  filtered_class_b;
    logic [8:0]  filtered_class_c;
    logic [8:0]  filtered_class_d;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       hdr_en;
    logic [2:0] hdr_sel;
    logic       class_en;
    logic [8:0] class_idx;
    logic       cell_end;
    logic       mul1_en;
    logic       mul2_en;
    logic       out_load;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic emit;
  } dp_status_t;

endpackage

[design/ycbd_ctrl.sv]
// Controller for the YOLO cell box decoder: channel position counter,
// decode sequencing and output valid. Depends on ycbd_pkg.
`timescale 1ns / 1ps

module ycbd_ctrl import ycbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  cfg_t       cfg_i,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o
);

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_MUL1 = 2'd1;
  localparam logic [1:0] ST_MUL2 = 2'd2;
  localparam logic [1:0] ST_EDGE = 2'd3;

  logic [1:0] state_q, state_d;
  logic [8:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;

  logic       accept;
  logic [8:0] class_idx;
  logic [9:0] eff_count;
  logic       last_class;

  assign in_ready_o  = (state_q == ST_ACC);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign class_idx   = pos_q - 9'(HEADER_WORDS);

  // Clamp class count into [1, MAX_CLASSES]
  always_comb begin
    if (cfg_i.class_count == 9'd0) begin
      eff_count = 10'd1;
    end else if ({1'b0, cfg_i.class_count} > 10'(MAX_CLASSES)) begin
      eff_count = 10'(MAX_CLASSES);
    end else begin
      eff_count = {1'b0, cfg_i.class_count};
    end
  end

  assign last_class = ({1'b0, class_idx} + 10'd1) >= eff_count;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.class_idx = class_idx;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_ACC: begin
        if (accept) begin
          if (pos_q < 9'(HEADER_WORDS)) begin
            cmd_o.hdr_en  = 1'b1;
            cmd_o.hdr_sel = pos_q[2:0];
            pos_d         = pos_q + 9'd1;
          end else begin
            cmd_o.class_en = 1'b1;
            if (last_class) begin
              cmd_o.cell_end = 1'b1;
              pos_d          = 9'd0;
              state_d        = ST_MUL1;
            end else begin
              pos_d = pos_q + 9'd1;
            end
          end
        end
      end
      ST_MUL1: begin
        cmd_o.mul1_en = 1'b1;
        state_d       = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2_en = 1'b1;
        state_d       = ST_EDGE;
      end
      ST_EDGE: begin
        // Drop a suppressed box; otherwise wait for the output register
        if (!status_i.emit) begin
          state_d = ST_ACC;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[design/ycbd_datapath.sv]
// Datapath for the YOLO cell box decoder: header capture, score tracking,
// two multiply stages and edge clamping into the output register. Depends on ycbd_pkg.
`timescale 1ns / 1ps

module ycbd_datapath import ycbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_word_t   in_word_i,
  input  cfg_t       cfg_i,
  input  ctl_cmd_t   cmd_i,
  output dp_status_t status_o,
  output out_word_t  out_word_o
);

  localparam int PROD_W = 2 * VALUE_FRAC_BITS;

  // Header channels
  logic [15:0] raw_x_q, raw_y_q, raw_w_q, raw_h_q, obj_q;
  // Running best of the current cell
  logic [15:0] best_score_q;
  logic [8:0]  best_class_q;
  // Final best and geometry of the cell under decode
  logic [15:0] fin_score_q;
  logic [8:0]  fin_class_q;
  logic [7:0]  cell_x_q, cell_y_q;
  logic [6:0]  stride_q;
  logic [9:0]  anc_w_q, anc_h_q;
  // Stage one
  logic [31:0]        wsq_q, hsq_q;
  logic signed [25:0] cxq_q, cyq_q;
  // Stage two
  logic [41:0]        hw_q, hh_q;
  logic signed [33:0] cxs_q, cys_q;

  out_word_t out_q;

  logic [PROD_W-1:0] prod;
  logic [15:0]       score;
  logic              better;
  logic [15:0]       nb_score;
  logic [8:0]        nb_class;

  logic signed [25:0] cxq_d, cyq_d;
  logic signed [50:0] cx2, cy2, hw2, hh2;

  function automatic logic [12:0] edge_px(logic signed [50:0] v, logic [12:0] lim);
    logic [18:0] px;
    px = v[50:32];
    if (v[50] || (v == '0)) begin
      return '0;
    end else if (px > {6'd0, lim}) begin
      return lim;
    end else begin
      return px[12:0];
    end
  endfunction

  assign prod     = {16'd0, obj_q} * {16'd0, in_word_i.channel_value};
  assign score    = prod[PROD_W-1:VALUE_FRAC_BITS];
  assign better   = score > best_score_q;
  assign nb_score = better ? score : best_score_q;
  assign nb_class = better ? cmd_i.class_idx : best_class_q;

  assign status_o.emit = (fin_class_q != NO_CLASS) &&
                         (fin_score_q > cfg_i.score_threshold) &&
                         (fin_class_q != cfg_i.filtered_class_a) &&
                         (fin_class_q != cfg_i.filtered_class_b) &&
                         (fin_class_q != cfg_i.filtered_class_c) &&
                         (fin_class_q != cfg_i.filtered_class_d);

  // Centre in Q.16: 2x - 0.5 + cell
  assign cxq_d = $signed({2'b00, cell_x_q, 16'd0}) + $signed({9'd0, raw_x_q, 1'b0})
               - 26'sd32768;
  assign cyq_d = $signed({2'b00, cell_y_q, 16'd0}) + $signed({9'd0, raw_y_q, 1'b0})
               - 26'sd32768;

  // Align to Q.32; half size (2w)^2/2 = 2 w^2 anchor
  assign cx2 = {cxs_q[33], cxs_q, 16'd0};
  assign cy2 = {cys_q[33], cys_q, 16'd0};
  assign hw2 = $signed({8'd0, hw_q, 1'b0});
  assign hh2 = $signed({8'd0, hh_q, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_score_q <= '0;
      best_class_q <= NO_CLASS;
      fin_score_q  <= '0;
      fin_class_q  <= NO_CLASS;
    end else if (cmd_i.class_en) begin
      if (cmd_i.cell_end) begin
        fin_score_q  <= nb_score;
        fin_class_q  <= nb_class;
        best_score_q <= '0;
        best_class_q <= NO_CLASS;
      end else begin
        best_score_q <= nb_score;
        best_class_q <= nb_class;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_en) begin
      case (cmd_i.hdr_sel)
        HDR_X:   raw_x_q <= in_word_i.channel_value;
        HDR_Y:   raw_y_q <= in_word_i.channel_value;
        HDR_W:   raw_w_q <= in_word_i.channel_value;
        HDR_H:   raw_h_q <= in_word_i.channel_value;
        default: obj_q   <= in_word_i.channel_value;
      endcase
    end
    if (cmd_i.cell_end) begin
      cell_x_q <= in_word_i.cell_x;
      cell_y_q <= in_word_i.cell_y;
      stride_q <= in_word_i.stride;
      anc_w_q  <= in_word_i.anchor_width;
      anc_h_q  <= in_word_i.anchor_height;
    end
    if (cmd_i.mul1_en) begin
      wsq_q <= {16'd0, raw_w_q} * {16'd0, raw_w_q};
      hsq_q <= {16'd0, raw_h_q} * {16'd0, raw_h_q};
      cxq_q <= cxq_d;
      cyq_q <= cyq_d;
    end
    if (cmd_i.mul2_en) begin
      hw_q  <= {10'd0, wsq_q} * {32'd0, anc_w_q};
      hh_q  <= {10'd0, hsq_q} * {32'd0, anc_h_q};
      cxs_q <= $signed({{8{cxq_q[25]}}, cxq_q}) * $signed({27'd0, stride_q});
      cys_q <= $signed({{8{cyq_q[25]}}, cyq_q}) * $signed({27'd0, stride_q});
    end
    if (cmd_i.out_load) begin
      out_q.class_id <= fin_class_q[7:0];
      out_q.score    <= fin_score_q;
      out_q.top      <= edge_px(cy2 - hh2, cfg_i.model_height);
      out_q.left     <= edge_px(cx2 - hw2, cfg_i.model_width);
      out_q.bottom   <= edge_px(cy2 + hh2, cfg_i.model_height);
      out_q.right    <= edge_px(cx2 + hw2, cfg_i.model_width);
    end
  end

  assign out_word_o = out_q;

endmodule

[design/yolo_cell_box_decoder.sv]
// Top level of the YOLO cell box decoder: configuration registers, controller
// and datapath. Depends on ycbd_pkg, ycbd_ctrl and ycbd_datapath.
`timescale 1ns / 1ps

// Decodes one grid cell of a detection head from a stream of 16-bit Q0.16
// words: x, y, w, h, objectness, then class_count class scores. The first
// class with the strictly greatest objectness*class score wins; after the
// last class word a box is produced if that score exceeds score_threshold and
// the class is not one of the four filtered ids. Cell position, stride and
// anchors are sampled from the word that carries the last class. Edges are
// floored and clamped to [0, model size].
// Timing: header and class words are taken one per cycle. After the last
// class word the input stalls through two registered multiply stages, then
// the edge add and clamp stage, and for as long as a box waits for the
// output register to empty. Earlier words of the next cell are taken while
// a finished box still sits in the output register.

module yolo_cell_box_decoder import ycbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o,
  input  logic      cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  cfg_t       cfg_q;
  ctl_cmd_t   cmd;
  dp_status_t status;

  // Configuration registers; write takes effect at the next edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_threshold  <= 16'd16384;
      cfg_q.class_count      <= 9'd80;
      cfg_q.model_width      <= 13'd640;
      cfg_q.model_height     <= 13'd640;
      cfg_q.filtered_class_a <= 9'd256;
      cfg_q.filtered_class_b <= 9'd256;
      cfg_q.filtered_class_c <= 9'd256;
      cfg_q.filtered_class_d <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SCORE_THRESHOLD: cfg_q.score_threshold  <= cfg_wdata_i;
        REG_CLASS_COUNT:     cfg_q.class_count      <= cfg_wdata_i[8:0];
        REG_MODEL_WIDTH:     cfg_q.model_width      <= cfg_wdata_i[12:0];
        REG_MODEL_HEIGHT:    cfg_q.model_height     <= cfg_wdata_i[12:0];
        REG_FILTER_A:        cfg_q.filtered_class_a <= cfg_wdata_i[8:0];
        REG_FILTER_B:        cfg_q.filtered_class_b <= cfg_wdata_i[8:0];
        REG_FILTER_C:        cfg_q.filtered_class_c <= cfg_wdata_i[8:0];
        REG_FILTER_D:        cfg_q.filtered_class_d <= cfg_wdata_i[8:0];
        default:             cfg_q.filtered_class_d <= cfg_wdata_i[8:0];
      endcase
    end
  end

  ycbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_i       (cfg_q),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ycbd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

  // Hold off input while the box of a finished cell is decoded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cell_end |=> !in_ready_o)
    else $error("input taken during box decode");

  // A shown box always beats the threshold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.score > cfg_q.score_threshold))
    else $error("box score not above threshold");

  // Edges stay ordered after flooring and clamping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_word_o.top <= out_word_o.bottom) &&
                     (out_word_o.left <= out_word_o.right)))
    else $error("box edges out of order");

  // A filtered class never reaches the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (({1'b0, out_word_o.class_id} != cfg_q.filtered_class_a) &&
                     ({1'b0, out_word_o.class_id} != cfg_q.filtered_class_b) &&
                     ({1'b0, out_word_o.class_id} != cfg_q.filtered_class_c) &&
                     ({1'b0, out_word_o.class_id} != cfg_q.filtered_class_d)))
    else $error("filtered class emitted");

endmodule

[sim/yolo_cell_box_decoder_test.sv]
// Self-checking bench for yolo_cell_box_decoder: streams grid cells word by word,
// predicts each decoded box and checks it. Depends on ycbd_pkg and the RTL only.
`timescale 1ns / 1ps

module yolo_cell_box_decoder_test;
  import ycbd_pkg::*;

  localparam int DRAIN_CYCLES   = 12;      // last class word to box, with margin
  localparam int SEGMENTS       = 12;
  localparam int SEGMENT_WORDS  = 120;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int REPORT_LIMIT   = 60;

  // Cell decoder prediction: mirrors the channel counter, header capture,
  // best-class search and box geometry, and holds the boxes still owed.
  class cell_box_predictor;
    logic [15:0] threshold;
    logic [8:0]  class_count;
    logic [12:0] width_lim;
    logic [12:0] height_lim;
    logic [8:0]  filter_ids [4];
    logic [8:0]  position;
    logic [15:0] raw_x, raw_y, raw_w, raw_h, objness;
    logic [15:0] best_score;
    logic [8:0]  best_class;
    out_word_t   pending_boxes [$];
    int unsigned mismatches;
    int unsigned boxes_checked;
    int unsigned cells_closed;

    function new();
      threshold  = 16'd16384;
      class_count = 9'd80;
      width_lim  = 13'd640;
      height_lim = 13'd640;
      foreach (filter_ids[i]) filter_ids[i] = 9'd256;
      position   = '0;
      raw_x = '0; raw_y = '0; raw_w = '0; raw_h = '0; objness = '0;
      best_score = '0;
      best_class = NO_CLASS;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_SCORE_THRESHOLD: threshold     = data;
        REG_CLASS_COUNT:     class_count   = data[8:0];
        REG_MODEL_WIDTH:     width_lim     = data[12:0];
        REG_MODEL_HEIGHT:    height_lim    = data[12:0];
        REG_FILTER_A:        filter_ids[0] = data[8:0];
        REG_FILTER_B:        filter_ids[1] = data[8:0];
        REG_FILTER_C:        filter_ids[2] = data[8:0];
        REG_FILTER_D:        filter_ids[3] = data[8:0];
        default: ;
      endcase
    endfunction

    // Floor a Q.32 edge to a pixel, clamp to [0, limit]. A 13-bit limit
    // never exceeds the output range, so no extra saturation is needed.
    function logic [12:0] clamp_edge(longint v, logic [12:0] lim);
      longint px;
      if (v <= 0) return '0;
      px = v >>> (2 * VALUE_FRAC_BITS);
      if (px > longint'(lim)) px = longint'(lim);
      return px[12:0];
    endfunction

    function void note_word(in_word_t w);
      int unsigned cls;
      int unsigned limit_count;
      logic [31:0] prod;
      logic [15:0] s;
      longint one, half, cx, cy, hw, hh;
      bit suppressed;
      out_word_t box;
      if (position < HEADER_WORDS) begin
        case (position[2:0])
          HDR_X:   raw_x   = w.channel_value;
          HDR_Y:   raw_y   = w.channel_value;
          HDR_W:   raw_w   = w.channel_value;
          HDR_H:   raw_h   = w.channel_value;
          HDR_OBJ: objness = w.channel_value;
          default: ;
        endcase
        position = position + 1'b1;
        return;
      end
      limit_count = class_count;
      if (limit_count < 1) limit_count = 1;
      if (limit_count > MAX_CLASSES) limit_count = MAX_CLASSES;
      cls  = position - HEADER_WORDS;
      prod = objness * w.channel_value;
      s    = prod[31:16];               // at most 65534, never saturates
      if (s > best_score) begin
        best_score = s;
        best_class = cls[8:0];
      end
      // Scoring the last class closes the cell, also when the count was
      // lowered under the current index mid-cell.
      if (cls + 1 < limit_count) begin
        position = position + 1'b1;
        return;
      end
      suppressed = 1'b0;
      foreach (filter_ids[i]) if (filter_ids[i] == best_class) suppressed = 1'b1;
      if (best_class != NO_CLASS && best_score > threshold && !suppressed) begin
        one  = longint'(1) << VALUE_FRAC_BITS;
        half = one >>> 1;
        cx = (2 * longint'(raw_x) - half + longint'(w.cell_x) * one) * longint'(w.stride) * one;
        cy = (2 * longint'(raw_y) - half + longint'(w.cell_y) * one) * longint'(w.stride) * one;
        hw = 2 * longint'(raw_w) * longint'(raw_w) * longint'(w.anchor_width);
        hh = 2 * longint'(raw_h) * longint'(raw_h) * longint'(w.anchor_height);
        box.class_id = best_class[7:0];
        box.score    = best_score;
        box.top      = clamp_edge(cy - hh, height_lim);
        box.left     = clamp_edge(cx - hw, width_lim);
        box.bottom   = clamp_edge(cy + hh, height_lim);
        box.right    = clamp_edge(cx + hw, width_lim);
        pending_boxes.push_back(box);
      end
      position   = '0;
      best_score = '0;
      best_class = NO_CLASS;
      cells_closed++;
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_box(out_word_t got);
      out_word_t want;
      if (pending_boxes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: box with none expected, expected nothing, actual %p", $time, got);
        return;
      end
      want = pending_boxes.pop_front();
      boxes_checked++;
      compare_field("class_id", want.class_id, got.class_id);
      compare_field("score",    want.score,    got.score);
      compare_field("top",      want.top,      got.top);
      compare_field("left",     want.left,     got.left);
      compare_field("bottom",   want.bottom,   got.bottom);
      compare_field("right",    want.right,    got.right);
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_word_t    in_word_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_word_t   out_word_o;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = '0;
  logic [15:0] cfg_wdata_i = '0;

  cell_box_predictor predictor = new();

  int send_idle_pct  = 21;
  int recv_stall_pct = 78;
  int unsigned words_sent;
  int unsigned settings_applied;
  int unsigned cycle_count;

  yolo_cell_box_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d boxes still owed",
               cycle_count, predictor.pending_boxes.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receive side: check every accepted box, then stall at random for the
  // next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) predictor.check_box(out_word_o);
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Random word: geometry is mostly near the grid origin with common strides,
  // sometimes anywhere in the field range, stride 0 and above 64 included.
  function automatic in_word_t random_word();
    in_word_t w;
    w.channel_value = 16'($urandom);
    w.cell_x = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
    w.cell_y = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
    case ($urandom_range(0, 3))
      0:       w.stride = 7'($urandom);
      1:       w.stride = 7'($urandom_range(1, 64));
      default: w.stride = 7'(8 << $urandom_range(0, 2));
    endcase
    w.anchor_width  = 10'($urandom);
    w.anchor_height = 10'($urandom);
    return w;
  endfunction

  function automatic logic [12:0] pick_dim();
    case ($urandom_range(0, 6))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd640;
      3:       return 13'd4096;
      4:       return 13'h1FFF;
      5:       return 13'($urandom_range(1, 4096));
      default: return 13'($urandom);
    endcase
  endfunction

  // Filter ids: unused marker, above the class range, a live class or any 8-bit id.
  function automatic logic [8:0] pick_filter(int live_classes);
    case ($urandom_range(0, 3))
      0:       return 9'd256;
      1:       return 9'h1FF;
      2:       return 9'($urandom_range(0, live_classes - 1));
      default: return 9'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one word, idling first at the current rate; hold it until taken.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predictor.note_word(w);
    words_sent++;
  endtask

  task automatic send_value(input logic [15:0] v);
    in_word_t w;
    w = random_word();
    w.channel_value = v;
    send_word(w);
  endtask

  // Last class word of a directed cell, with the geometry it samples.
  task automatic send_closing_word(input logic [15:0] v, input logic [7:0] cx,
                                   input logic [7:0] cy, input logic [6:0] st,
                                   input logic [9:0] aw, input logic [9:0] ah);
    in_word_t w;
    w.channel_value = v;
    w.cell_x = cx;
    w.cell_y = cy;
    w.stride = st;
    w.anchor_width  = aw;
    w.anchor_height = ah;
    send_word(w);
  endtask

  // Drop valid, wait for every owed box, then for the decode pipe to empty.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (predictor.pending_boxes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    predictor.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One well-formed cell with random content: objectness mostly high so
  // boxes come often, ties and zero scores mixed into the class words.
  task automatic send_random_cell(input int live_classes);
    logic [15:0] v, prev;
    int k;
    send_value(16'($urandom));
    send_value(16'($urandom));
    for (k = 0; k < 2; k++) begin
      if ($urandom_range(0, 1) == 0) send_value(16'($urandom_range(0, 24000)));
      else send_value(16'($urandom));
    end
    case ($urandom_range(0, 19))
      0, 1, 2: send_value(16'd0);
      3, 4, 5: send_value(16'($urandom));
      default: send_value(16'($urandom_range(24000, 65535)));
    endcase
    prev = 16'($urandom);
    for (k = 0; k < live_classes; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2: v = prev;
        3, 4:    v = 16'd0;
        default: v = 16'($urandom);
      endcase
      send_value(v);
      prev = v;
    end
  endtask

  initial begin
    int seg;
    int live_classes;
    int seg_words;
    logic [15:0] thr;
    logic [8:0]  cnt;
    logic [12:0] wdim, hdim;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cells, threshold 0, model size 4096; the first three have one class each.
    set_reg(REG_SCORE_THRESHOLD, 16'd0);
    set_reg(REG_CLASS_COUNT, 16'd1);
    set_reg(REG_MODEL_WIDTH, 16'd4096);
    set_reg(REG_MODEL_HEIGHT, 16'd4096);
    // Full-scale channels at the far grid corner: edges clamp to model size.
    repeat (5) send_value(16'hFFFF);
    send_closing_word(16'hFFFF, 8'hFF, 8'hFF, 7'd64, 10'h3FF, 10'h3FF);
    // Zero offset and size at the origin: centre sits left of 0, edges clamp to 0.
    repeat (4) send_value(16'h0000);
    send_value(16'hFFFF);
    send_closing_word(16'hFFFF, 8'd0, 8'd0, 7'd64, 10'd0, 10'd0);
    // Class count 0 behaves as one class; zero objectness leaves no winner.
    drain_block();
    set_reg(REG_CLASS_COUNT, 16'd0);
    repeat (4) send_value(16'($urandom));
    send_value(16'h0000);
    send_closing_word(16'hFFFF, 8'd3, 8'd5, 7'd8, 10'd40, 10'd60);
    // Lower the class count mid-cell: class 3 is scored and closes the cell;
    // classes 1 and 2 tie and the first of them must win.
    drain_block();
    set_reg(REG_CLASS_COUNT, 16'd4);
    repeat (4) send_value(16'h4000);
    send_value(16'hC000);
    send_value(16'd100);
    send_value(16'h9000);
    send_value(16'h9000);
    drain_block();
    set_reg(REG_CLASS_COUNT, 16'd2);
    send_value(16'h1000);

    // Random segments, each under its own register setting; the idle pattern
    // moves from slow receiver to slow sender to none across the run.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      drain_block();
      case (seg * 3 / SEGMENTS)
        0:       begin send_idle_pct = 21; recv_stall_pct = 78; end
        1:       begin send_idle_pct = 78; recv_stall_pct = 21; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      if (seg == 2) thr = 16'hFFFF;
      else if (seg % 4 == 0) thr = 16'd0;
      else thr = 16'($urandom_range(0, 45000));
      if (seg == 4) cnt = 9'd256;
      else if (seg == 9) cnt = 9'h1FF;
      else if (seg % 5 == 1) cnt = 9'd0;
      else cnt = 9'($urandom_range(1, 8));
      live_classes = (cnt == 0) ? 1 : (cnt > MAX_CLASSES) ? MAX_CLASSES : int'(cnt);
      wdim = (seg == 1) ? 13'd1 : (seg == 3) ? 13'h1FFF : pick_dim();
      hdim = (seg == 1) ? 13'd1 : (seg == 3) ? 13'h1FFF : pick_dim();
      // Junk in the unused upper data bits must be dropped by the block.
      set_reg(REG_SCORE_THRESHOLD, thr);
      set_reg(REG_CLASS_COUNT,  {7'($urandom), cnt});
      set_reg(REG_MODEL_WIDTH,  {3'($urandom), wdim});
      set_reg(REG_MODEL_HEIGHT, {3'($urandom), hdim});
      set_reg(REG_FILTER_A, {7'($urandom), pick_filter(live_classes)});
      set_reg(REG_FILTER_B, {7'($urandom), pick_filter(live_classes)});
      set_reg(REG_FILTER_C, {7'($urandom), pick_filter(live_classes)});
      set_reg(REG_FILTER_D, {7'($urandom), pick_filter(live_classes)});
      settings_applied++;
      seg_words = 0;
      while (seg_words < SEGMENT_WORDS) begin
        send_random_cell(live_classes);
        seg_words += HEADER_WORDS + live_classes;
      end
    end

    drain_block();
    $display("Streamed %0d words over %0d cells and %0d random register settings;",
             words_sent, predictor.cells_closed, settings_applied);
    $display("checked %0d boxes, %0d field mismatches",
             predictor.boxes_checked, predictor.mismatches);
    if (predictor.mismatches == 0 && predictor.pending_boxes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
